>>> hw/rtl/kpe_pkg.sv
package kpe_pkg;

    // Key table size and the derived index width.
    localparam int NUM_KEYS   = 256;
    localparam int KEY_IDX_W  = $clog2(NUM_KEYS);

    // Fixed field widths.
    localparam int CODE_W     = 8;
    localparam int TICK_W     = 10;
    localparam int COUNT_W    = 11;

    // Codes below this value are never reported.
    localparam logic [CODE_W-1:0]  FIRST_CODE = CODE_W'(8);
    localparam logic [COUNT_W-1:0] COUNT_MAX  = {COUNT_W{1'b1}};

    // Configuration register indexes.
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_DELAY = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_RATE  = 1'b1;

    localparam logic [TICK_W-1:0] DELAY_RESET = TICK_W'(50);
    localparam logic [TICK_W-1:0] RATE_RESET  = TICK_W'(3);

    // Beat widths on the stream ports.
    localparam int S_DATA_W = 16;
    localparam int M_DATA_W = 16;

    typedef struct packed {
        logic caps;
        logic alt;
        logic shift;
        logic ctrl;
    } key_flags_t;

    typedef struct packed {
        logic [CODE_W-1:0] code;
        logic              down;
        logic              modifier;
        key_flags_t        flags;
    } key_sample_t;

    // Outcome of one hold-counter step.
    typedef struct packed {
        logic               emit;
        logic [COUNT_W-1:0] next_count;
    } repeat_res_t;

endpackage

>>> hw/rtl/kpe_ram.sv
module kpe_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> hw/rtl/kpe_repeat.sv
module kpe_repeat
    import kpe_pkg::*;
(
    input  logic [COUNT_W-1:0] count,
    input  logic [TICK_W-1:0]  delay,
    input  logic [TICK_W-1:0]  rate,
    output repeat_res_t        res
);

    logic [COUNT_W:0]   sum;
    logic [COUNT_W-1:0] stepped;
    logic [COUNT_W-1:0] delay_ext;
    logic [COUNT_W-1:0] window;

    // Advance by one, saturating at the counter limit.
    assign sum       = {1'b0, count} + (COUNT_W+1)'(1);
    assign stepped   = sum[COUNT_W] ? COUNT_MAX : sum[COUNT_W-1:0];
    assign delay_ext = {1'b0, delay};
    assign window    = {1'b0, delay} + {1'b0, rate};

    always_comb begin
        res.emit       = 1'b0;
        res.next_count = stepped;
        priority if (stepped == delay_ext) begin
            res.emit = 1'b1;
        end else if (rate != '0 && stepped > delay_ext && stepped >= window) begin
            // Fold back to the delay so the count stays bounded.
            res.emit       = 1'b1;
            res.next_count = delay_ext;
        end else begin
            // Neither the first repeat nor a later one: the count just steps.
            res.emit       = 1'b0;
            res.next_count = stepped;
        end
    end

endmodule

>>> hw/rtl/key_press_edge_and_typematic_repeat.sv
// Channel   Dir  Handshake          Payload
// sample    in   s_tvalid/s_tready  s_tdata: code, down, ctrl, shift, alt, caps; s_tuser: modifier
// report    out  m_tvalid/m_tready  m_tdata: code, ctrl, shift, alt, caps
// config    in   cfg_we             cfg_index, cfg_wdata
//
// A sample beat can be taken every cycle unless the report output stalls; reports are registered.
// The per-key hold counter lives in a registered-read RAM: the read issues when the
// sample is taken and the write lands as it leaves the compute stage, so a one-entry bypass covers
// a repeat of the same key on the next beat. The down bits sit in flip-flops.
// Reset (aresetn low, synchronous) clears all down bits, so no clearing pass is needed.
// A stalled report holds the compute stage, which in turn holds the sample input.
module key_press_edge_and_typematic_repeat
    import kpe_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,

    input  logic                 s_tvalid,
    output logic                 s_tready,
    // [7:0] key_code, [8] key_down, [9] ctrl_held, [10] shift_held, [11] alt_held,
    // [12] caps_on, [15:13] zero
    input  logic [S_DATA_W-1:0]  s_tdata,
    // [0] modifier_key
    input  logic                 s_tuser,

    output logic                 m_tvalid,
    input  logic                 m_tready,
    // [7:0] emitted_code, [8] ctrl_out, [9] shift_out, [10] alt_out, [11] caps_out,
    // [15:12] zero
    output logic [M_DATA_W-1:0]  m_tdata,

    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [TICK_W-1:0]    cfg_wdata
);

    localparam int CMP_W = KEY_IDX_W + 1;
    localparam logic [CMP_W-1:0] KEY_LIMIT = CMP_W'(NUM_KEYS);

    // Configuration registers.
    logic [TICK_W-1:0] delay_reg;
    logic [TICK_W-1:0] rate_reg;

    // Compute stage: the accepted sample, aligned with the RAM read data.
    logic        s1_valid_reg;
    key_sample_t s1_sample_reg;

    // Per-key down bits.
    logic [NUM_KEYS-1:0] was_down_reg;

    // Last hold-counter write, for a read that crossed it.
    logic                 byp_valid_reg;
    logic [KEY_IDX_W-1:0] byp_addr_reg;
    logic [COUNT_W-1:0]   byp_data_reg;

    // Result register.
    logic               m_valid_reg;
    logic [CODE_W-1:0]  m_code_reg;
    key_flags_t         m_flags_reg;

    key_sample_t          in_sample;
    logic                 advance;
    logic                 in_take;
    logic                 in_range;
    logic [KEY_IDX_W-1:0] s1_idx;
    logic                 prev_down;
    logic [COUNT_W-1:0]   ram_rdata;
    logic [COUNT_W-1:0]   cur_count;
    repeat_res_t          rep;
    logic                 emit;
    logic                 cnt_we;
    logic [COUNT_W-1:0]   cnt_wdata;
    logic                 m_valid_next;

    assign in_sample.code     = s_tdata[7:0];
    assign in_sample.down     = s_tdata[8];
    assign in_sample.flags    = '{caps: s_tdata[12], alt: s_tdata[11],
                                  shift: s_tdata[10], ctrl: s_tdata[9]};
    assign in_sample.modifier = s_tuser;

    // The compute stage moves on whenever the result register is free or being emptied.
    assign advance  = s1_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready = !s1_valid_reg || advance;
    assign in_take  = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            delay_reg <= DELAY_RESET;
            rate_reg  <= RATE_RESET;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_DELAY: delay_reg <= cfg_wdata;
                REG_RATE:  rate_reg  <= cfg_wdata;
                default:   ;
            endcase
        end
    end

    kpe_ram #(
        .WIDTH (COUNT_W),
        .DEPTH (NUM_KEYS)
    ) u_count_ram (
        .clk   (aclk),
        .we    (cnt_we),
        .waddr (s1_idx),
        .wdata (cnt_wdata),
        .re    (in_take),
        .raddr (in_sample.code[KEY_IDX_W-1:0]),
        .rdata (ram_rdata)
    );

    assign in_range  = (s1_sample_reg.code >= FIRST_CODE) &&
                       ({1'b0, s1_sample_reg.code[CODE_W-1:0]} < CMP_W'(KEY_LIMIT));
    assign s1_idx    = s1_sample_reg.code[KEY_IDX_W-1:0];
    assign prev_down = was_down_reg[s1_idx];
    assign cur_count = (byp_valid_reg && byp_addr_reg == s1_idx) ? byp_data_reg : ram_rdata;

    kpe_repeat u_repeat (
        .count (cur_count),
        .delay (delay_reg),
        .rate  (rate_reg),
        .res   (rep)
    );

    // A new press restarts the counter at zero; a held ordinary key steps it.
    // A held modifier leaves it alone, and a release needs no write because
    // the count of a key that is up is never read.
    always_comb begin
        emit      = 1'b0;
        cnt_we    = 1'b0;
        cnt_wdata = rep.next_count;
        if (advance && in_range && s1_sample_reg.down) begin
            if (!prev_down) begin
                emit      = !s1_sample_reg.modifier;
                cnt_we    = 1'b1;
                cnt_wdata = '0;
            end else if (!s1_sample_reg.modifier) begin
                emit   = rep.emit;
                cnt_we = 1'b1;
            end
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (advance) begin
            m_valid_next = emit;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            was_down_reg  <= '0;
            byp_valid_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (s_tready) begin
                s1_valid_reg <= s_tvalid;
            end
            if (advance && in_range) begin
                was_down_reg[s1_idx] <= s1_sample_reg.down;
            end
            if (cnt_we) begin
                byp_valid_reg <= 1'b1;
            end
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_take) begin
            s1_sample_reg <= in_sample;
        end
        if (cnt_we) begin
            byp_addr_reg <= s1_idx;
            byp_data_reg <= cnt_wdata;
        end
        if (advance && emit) begin
            m_code_reg  <= s1_sample_reg.code;
            m_flags_reg <= s1_sample_reg.flags;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {4'b0000, m_flags_reg.caps, m_flags_reg.alt,
                       m_flags_reg.shift, m_flags_reg.ctrl, m_code_reg};

`ifndef SYNTHESIS
    // Codes below the first reportable code never come out.
    a_code_floor: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[7:0] >= FIRST_CODE))
        else $error("reported code below the first reportable code");

    // The input only backs up when the result register is stalled.
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (m_valid_reg && !m_tready))
        else $error("sample input stalled without a stalled result");

    // Reset leaves every key up.
    a_reset_clear: assert property (@(posedge aclk)
        !aresetn |=> (was_down_reg == '0))
        else $error("down bits not cleared by reset");

    // A press of a key that was up writes a zero count.
    a_press_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_we && !prev_down) |-> (cnt_wdata == '0))
        else $error("new press did not restart the hold counter");
`endif

endmodule
